>>> hdl/cbf_pkg.sv
// Shared types, register codes and helper functions for the counting Bloom filter.
package cbf_pkg;

    // Field and port widths fixed by the request format
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned DIVIDEND_W   = 64;
    localparam int unsigned RADIX_BITS   = 4;
    localparam int unsigned STORE_AW_MAX = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_FUNCS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CW_LOG2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0    = 3'd3;

    // Request kinds
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Mersenne prime used by the hash
    localparam logic [31:0] HASH_PRIME = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key;
    } cbf_in_t;

    typedef struct packed {
        logic        present;
        logic [7:0]  min_count;
        logic [2:0]  saturated_hits;
        logic [31:0] saturation_total;
    } cbf_out_t;

    typedef struct packed {
        logic                    wr_en;
        logic [STORE_AW_MAX-1:0] wr_addr;
        logic [7:0]              wr_data;
        logic [STORE_AW_MAX-1:0] rd_addr;
    } cbf_store_req_t;

    // Signed remainder by the prime, sign-extended to 64 bits as unsigned
    function automatic logic [DIVIDEND_W-1:0] fold_hash(input logic [31:0] v);
        logic [31:0]           mag;
        logic [31:0]           r;
        logic [DIVIDEND_W-1:0] u;
        mag = 32'd0 - v;
        if (!v[31])
        begin
            r = (v == HASH_PRIME) ? 32'd0 : v;
            u = {32'd0, r};
        end
        else
        begin
            if (mag == 32'h8000_0000)
                r = 32'd1;
            else if (mag == HASH_PRIME)
                r = 32'd0;
            else
                r = mag;
            u = 64'd0 - {32'd0, r};
        end
        return u;
    endfunction

    // All-ones mask of one counter for a given log2 width
    function automatic logic [7:0] counter_mask(input logic [1:0] lg);
        logic [7:0] m;
        unique case (lg)
            2'd0: m = 8'h01;
            2'd1: m = 8'h03;
            2'd2: m = 8'h0F;
            2'd3: m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/cbf_mod_unit.sv
// Iterative remainder unit: 64-bit dividend modulo a narrow divisor, a few bits per cycle.
module cbf_mod_unit #(
    parameter int unsigned DIVISOR_W = 17
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cbf_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]           divisor,
    output logic                           done,
    output logic [DIVISOR_W-1:0]           remainder
);

    localparam int unsigned STEPS = cbf_pkg::DIVIDEND_W / cbf_pkg::RADIX_BITS;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [cbf_pkg::DIVIDEND_W-1:0] shift_reg;
    logic [cbf_pkg::DIVIDEND_W-1:0] shift_next;
    logic [DIVISOR_W-1:0]           rem_reg;
    logic [DIVISOR_W-1:0]           rem_next;

    // Shift in dividend bits, subtract the divisor whenever it fits
    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        for (int k = 0; k < cbf_pkg::RADIX_BITS; k++)
        begin
            trial = {rem_next, shift_next[cbf_pkg::DIVIDEND_W-1]};
            if (trial >= {1'b0, divisor})
                trial = trial - {1'b0, divisor};
            rem_next   = trial[DIVISOR_W-1:0];
            shift_next = {shift_next[cbf_pkg::DIVIDEND_W-2:0], 1'b0};
        end
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and remaining dividend bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/cbf_store.sv
// Byte-wide counter store with a clearing sweep after reset.
module cbf_store #(
    parameter int unsigned DEPTH = 65536
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbf_pkg::cbf_store_req_t req,
    output logic [7:0]              rd_data,
    output logic                    ready
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Walk every byte once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Write one byte, read one byte, registered
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= 8'd0;
        else if (req.wr_en)
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        rd_data_reg <= mem[req.rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

>>> hdl/counting_bloom_filter.sv
// Counting Bloom filter top level: configuration, sequencer and counter update.
//
// Each request adds or queries one 32-bit key. For every hash function in use the block
// multiplies the key by the upper half of the function's coefficient, adds the lower half,
// folds the result by 2^31-1, and reduces it modulo the table size in a shared iterative
// remainder unit that retires four bits per cycle; the selected counter is then read, and
// for an add incremented, in a byte store with one read and one write port. Each hash
// function passes through the multiply, fold, remainder, read and update states in turn;
// after the last function the result is registered, and only then is a new request taken.
// The result sits in an output register, and the next request is accepted while it waits.
// After reset the store is cleared one byte per cycle, during which no request is accepted;
// configuration writes are taken at any time.
module counting_bloom_filter #(
    parameter int unsigned MAX_TABLE_ENTRIES = 65536,
    parameter int unsigned MAX_HASH_FUNCS    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cbf_pkg::cbf_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cbf_pkg::cbf_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int unsigned TW  = $clog2(MAX_TABLE_ENTRIES + 1);
    localparam int unsigned AW  = $clog2(MAX_TABLE_ENTRIES);
    localparam int unsigned FIW = (MAX_HASH_FUNCS > 1) ? $clog2(MAX_HASH_FUNCS) : 1;
    localparam int unsigned FCW = $clog2(MAX_HASH_FUNCS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_MOD    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    // Configuration
    logic [2:0]  num_funcs_reg;
    logic [16:0] table_size_reg;
    logic [1:0]  cw_log2_reg;
    logic [31:0] coeff_reg [MAX_HASH_FUNCS];

    // Control
    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [FIW-1:0] func_reg;
    logic           out_valid_reg;
    logic [31:0]    skip_total_reg;

    // Per-request working values
    logic              req_type_reg;
    logic [31:0]       key_reg;
    logic [31:0]       hash_reg;
    logic [AW-1:0]     n_reg;
    logic [7:0]        min_reg;
    logic              all_nz_reg;
    logic [2:0]        hits_reg;
    cbf_pkg::cbf_out_t out_reg;

    logic [FCW-1:0] eff_funcs;
    logic [FIW-1:0] func_last;
    logic [TW-1:0]  eff_size;
    logic [31:0]    coeff_cur;
    logic [47:0]    prod;
    logic [31:0]    hash_next;
    logic [cbf_pkg::CFG_IDX_W-1:0] coeff_off;

    logic           accept;
    logic           store_ready;
    logic           mod_start;
    logic           mod_done;
    logic [TW-1:0]  mod_rem;
    logic [AW-1:0]  byte_addr;
    logic [2:0]     pos;
    logic [7:0]     mask;
    logic [7:0]     rd_data;
    logic [7:0]     cval;
    logic           full;
    logic [7:0]     new_byte;
    logic           load_out;
    logic           last_func;
    cbf_pkg::cbf_store_req_t store_req;

    // Clamp the hash count and table size
    always_comb
    begin
        if (num_funcs_reg == 3'd0)
            eff_funcs = FCW'(1);
        else if (32'(num_funcs_reg) > MAX_HASH_FUNCS)
            eff_funcs = FCW'(MAX_HASH_FUNCS);
        else
            eff_funcs = FCW'(num_funcs_reg);

        if (table_size_reg == 17'd0)
            eff_size = TW'(1);
        else if (32'(table_size_reg) > MAX_TABLE_ENTRIES)
            eff_size = TW'(MAX_TABLE_ENTRIES);
        else
            eff_size = TW'(table_size_reg);
    end

    assign func_last = FIW'(eff_funcs - FCW'(1));
    assign last_func = (func_reg == func_last);
    assign coeff_off = cfg_index - cbf_pkg::REG_COEFF_0;

    // Multiply the key by the upper half of this function's coefficient and add its lower half as offset
    assign coeff_cur = coeff_reg[func_reg];
    assign prod      = 48'(coeff_cur[31:16]) * 48'(key_reg);
    assign hash_next = prod[31:0] + {16'd0, coeff_cur[15:0]};

    // Locate the counter inside the byte store
    always_comb
    begin
        unique case (cw_log2_reg)
            2'd0:
            begin
                byte_addr = n_reg >> 3;
                pos       = n_reg[2:0];
            end
            2'd1:
            begin
                byte_addr = n_reg >> 2;
                pos       = {n_reg[1:0], 1'b0};
            end
            2'd2:
            begin
                byte_addr = n_reg >> 1;
                pos       = {n_reg[0], 2'b00};
            end
            2'd3:
            begin
                byte_addr = n_reg;
                pos       = 3'd0;
            end
            default:
            begin
                byte_addr = n_reg;
                pos       = 3'd0;
            end
        endcase
    end

    // Extract the counter and build the incremented byte
    assign mask     = cbf_pkg::counter_mask(cw_log2_reg);
    assign cval     = (rd_data >> pos) & mask;
    assign full     = (cval == mask);
    assign new_byte = (rd_data & ~(mask << pos)) | (((cval + 8'd1) & mask) << pos);

    always_comb
    begin
        store_req.wr_en   = (state_reg == S_UPDATE) && (req_type_reg == cbf_pkg::REQ_ADD)
                            && !full;
        store_req.wr_addr = cbf_pkg::STORE_AW_MAX'(byte_addr);
        store_req.wr_data = new_byte;
        store_req.rd_addr = cbf_pkg::STORE_AW_MAX'(byte_addr);
    end

    assign in_ready  = (state_reg == S_IDLE) && store_ready;
    assign accept    = in_valid && in_ready;
    assign mod_start = (state_reg == S_FOLD);
    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    cbf_mod_unit #(
        .DIVISOR_W (TW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (cbf_pkg::fold_hash(hash_reg)),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cbf_store #(
        .DEPTH (MAX_TABLE_ENTRIES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_data),
        .ready   (store_ready)
    );

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_HASH;
            S_HASH:   state_next = S_FOLD;
            S_FOLD:   state_next = S_MOD;
            S_MOD:    if (mod_done) state_next = S_READ;
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = last_func ? S_FINISH : S_HASH;
            S_FINISH: if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and the running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skip_total_reg <= 32'd0;
            num_funcs_reg  <= 3'd4;
            table_size_reg <= 17'h10000;
            cw_log2_reg    <= 2'd2;
            for (int i = 0; i < MAX_HASH_FUNCS; i++)
                coeff_reg[i] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
                func_reg <= '0;
            else if ((state_reg == S_UPDATE) && !last_func)
                func_reg <= func_reg + 1'b1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if ((state_reg == S_UPDATE) && (req_type_reg == cbf_pkg::REQ_ADD) && full
                && (skip_total_reg != 32'hFFFF_FFFF))
                skip_total_reg <= skip_total_reg + 32'd1;

            if (cfg_we)
            begin
                if (cfg_index == cbf_pkg::REG_NUM_FUNCS)
                    num_funcs_reg <= cfg_wdata[2:0];
                else if (cfg_index == cbf_pkg::REG_TABLE_SIZE)
                    table_size_reg <= cfg_wdata[16:0];
                else if (cfg_index == cbf_pkg::REG_CW_LOG2)
                    cw_log2_reg <= cfg_wdata[1:0];
                else if ((cfg_index >= cbf_pkg::REG_COEFF_0)
                         && (32'(coeff_off) < MAX_HASH_FUNCS))
                    coeff_reg[coeff_off[FIW-1:0]] <= cfg_wdata;
            end
        end
    end

    // Request working values and the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= in_data.req_type;
            key_reg      <= $unsigned(in_data.key);
            min_reg      <= 8'hFF;
            all_nz_reg   <= 1'b1;
            hits_reg     <= 3'd0;
        end

        if (state_reg == S_HASH)
            hash_reg <= hash_next;

        if ((state_reg == S_MOD) && mod_done)
            n_reg <= mod_rem[AW-1:0];

        if (state_reg == S_UPDATE)
        begin
            if (cval < min_reg)
                min_reg <= cval;
            if (cval == 8'd0)
                all_nz_reg <= 1'b0;
            if ((req_type_reg == cbf_pkg::REQ_ADD) && full)
                hits_reg <= hits_reg + 3'd1;
        end

        if (load_out)
        begin
            out_reg.present          <= (req_type_reg == cbf_pkg::REQ_QUERY) && all_nz_reg;
            out_reg.min_count        <= min_reg;
            out_reg.saturated_hits   <= (req_type_reg == cbf_pkg::REQ_QUERY) ? 3'd0 : hits_reg;
            out_reg.saturation_total <= skip_total_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
